// ----- hdl/dsdh_pkg.sv -----
// Shared types, constants and build-time table functions for the damped sliding DFT.
// Depends on nothing; every other module of the block but dsdh_ram imports it.
package dsdh_pkg;

  localparam int SAMPLE_COUNT_DEF = 64;
  localparam int BIN_COUNT_DEF    = 32;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int BIN_W     = 28;
  localparam int TW_W      = 18;
  localparam int IDX_W     = 5;
  localparam int MAG_W     = 48;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_START_BIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BIN   = 2'd1;

  localparam logic [63:0] TWO_PI_Q36 = 64'h0000_0064_87ED_5111;
  localparam longint      DAMP_Q24   = 64'sd16775538;

  typedef struct packed {
    logic signed [BIN_W-1:0] re;
    logic signed [BIN_W-1:0] im;
  } bin_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DELTA,
    ST_ROT
  } dsdh_state_t;

  typedef enum logic [1:0] {
    WM_MID,
    WM_LO,
    WM_HI
  } win_mode_t;

  // Divide by 2^sh, rounding half up.
  function automatic longint rnd_shift(input longint v, input int sh);
    longint half;
    half = longint'(1) <<< (sh - 1);
    return (v + half) >>> sh;
  endfunction

  // Damped twiddle r*e^(j*2*pi*k/N) in Q1.17, packed as {re, im}.
  // Cosine and sine come from a 15-term integer Taylor series.
  function automatic logic [2*TW_W-1:0] twiddle(input int K, input int SampleCount);
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] xs;
    logic [63:0] x2;
    logic [63:0] term;
    longint      c;
    longint      s;
    longint      tre;
    longint      tim;
    logic        neg;
    m   = 64'(K % SampleCount);
    neg = 1'b0;
    if (2 * m > 64'(SampleCount)) begin
      m   = 64'(SampleCount) - m;
      neg = 1'b1;
    end
    x    = (TWO_PI_Q36 * m + 64'(SampleCount / 2)) / 64'(SampleCount);
    xs   = x >> 16;
    x2   = (xs * xs) >> 20;
    term = 64'd1 << 36;
    c    = longint'(term);
    for (int n = 1; n <= 14; n++) begin
      term = ((term * x2) >> 20) / 64'((2 * n - 1) * (2 * n));
      c    = ((n & 1) != 0) ? c - longint'(term) : c + longint'(term);
    end
    term = x;
    s    = longint'(x);
    for (int n = 1; n <= 14; n++) begin
      term = ((term * x2) >> 20) / 64'((2 * n) * (2 * n + 1));
      s    = ((n & 1) != 0) ? s - longint'(term) : s + longint'(term);
    end
    if (neg) begin
      s = -s;
    end
    tre = rnd_shift(c * DAMP_Q24, 43);
    tim = rnd_shift(s * DAMP_Q24, 43);
    return {TW_W'(tre), TW_W'(tim)};
  endfunction

  // r^N in Q1.17 from N rounded Q8.24 products.
  function automatic logic [TW_W-1:0] rpow_q17(input int SampleCount);
    longint p;
    p = longint'(1) <<< 24;
    for (int n = 0; n < SampleCount; n++) begin
      p = rnd_shift(p * DAMP_Q24, 24);
    end
    return TW_W'(rnd_shift(p, 7));
  endfunction

endpackage

// ----- hdl/dsdh_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module dsdh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/dsdh_cell.sv -----
// One storage cell of the bin ring: holds one complex bin and passes it on.
// Depends on dsdh_pkg.
module dsdh_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  dsdh_pkg::bin_t d,
  output dsdh_pkg::bin_t q
);
  import dsdh_pkg::*;

  bin_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

// ----- hdl/dsdh_upd.sv -----
// Bin update unit at the head of the ring: (bin + delta) times the damped twiddle when do_upd is set.
// Depends on dsdh_pkg for the bin type and the build-time twiddle function.
module dsdh_upd #(
  parameter int SAMPLE_COUNT = dsdh_pkg::SAMPLE_COUNT_DEF,
  parameter int BIN_COUNT    = dsdh_pkg::BIN_COUNT_DEF,
  parameter int DELTA_W      = dsdh_pkg::SAMPLE_WIDTH_DEF + 10
) (
  input  logic [$clog2(BIN_COUNT)-1:0] tag,
  input  logic                         do_upd,
  input  logic signed [DELTA_W-1:0]    delta,
  input  dsdh_pkg::bin_t               cur,
  output dsdh_pkg::bin_t               nxt
);
  import dsdh_pkg::*;

  localparam int SRW = ((DELTA_W > BIN_W) ? DELTA_W : BIN_W) + 1;
  localparam int PRW = SRW + TW_W;
  localparam int NW  = PRW + 1;
  localparam int RW  = NW - 17;
  localparam logic signed [RW-1:0] BMAX = RW'((64'sd1 <<< (BIN_W - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] BMIN = RW'(-(64'sd1 <<< (BIN_W - 1)));

  logic signed [TW_W-1:0] tw_re_tab [BIN_COUNT];
  logic signed [TW_W-1:0] tw_im_tab [BIN_COUNT];

  for (genvar g = 0; g < BIN_COUNT; g++) begin : g_tw
    localparam logic [2*TW_W-1:0] TW = twiddle(g, SAMPLE_COUNT);
    assign tw_re_tab[g] = TW[2*TW_W-1:TW_W];
    assign tw_im_tab[g] = TW[TW_W-1:0];
  end

  logic signed [TW_W-1:0] wre;
  logic signed [TW_W-1:0] wim;
  logic signed [SRW-1:0]  sr;
  logic signed [SRW-1:0]  si;
  logic signed [PRW-1:0]  p_rr;
  logic signed [PRW-1:0]  p_ii;
  logic signed [PRW-1:0]  p_ir;
  logic signed [PRW-1:0]  p_ri;
  logic signed [NW-1:0]   nr;
  logic signed [NW-1:0]   ni;
  logic signed [RW-1:0]   rr;
  logic signed [RW-1:0]   ri;

  function automatic logic signed [BIN_W-1:0] sat_bin(input logic signed [RW-1:0] v);
    if (v > BMAX) begin
      return BIN_W'(BMAX);
    end else if (v < BMIN) begin
      return BIN_W'(BMIN);
    end
    return BIN_W'(v);
  endfunction

  always_comb begin
    wre  = tw_re_tab[tag];
    wim  = tw_im_tab[tag];
    sr   = SRW'(cur.re) + SRW'(delta);
    si   = SRW'(cur.im);
    p_rr = wre * sr;
    p_ii = wim * si;
    p_ir = wre * si;
    p_ri = wim * sr;
    nr   = NW'(p_rr) - NW'(p_ii) + NW'(32'sd65536);
    ni   = NW'(p_ir) + NW'(p_ri) + NW'(32'sd65536);
    rr   = $signed(nr[NW-1:17]);
    ri   = $signed(ni[NW-1:17]);
    nxt  = cur;
    if (do_upd) begin
      nxt.re = sat_bin(rr);
      nxt.im = sat_bin(ri);
    end
  end

endmodule

// ----- hdl/dsdh_mag.sv -----
// Result pipeline: Hann window term, squared magnitudes and the output register.
// Depends on dsdh_pkg for the bin type, the window mode codes and field widths.
module dsdh_mag (
  input  logic                           clk,
  input  logic                           rst_n,
  output logic                           adv,
  input  logic                           in_valid,
  input  logic [dsdh_pkg::IDX_W-1:0]     in_idx,
  input  logic                           in_last,
  input  dsdh_pkg::win_mode_t            mode,
  input  dsdh_pkg::bin_t                 c,
  input  dsdh_pkg::bin_t                 l,
  input  dsdh_pkg::bin_t                 r,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dsdh_pkg::IDX_W-1:0]     out_bin_index,
  output logic [dsdh_pkg::MAG_W-1:0]     out_mag_sq,
  output logic [dsdh_pkg::MAG_W-1:0]     out_win_sq,
  output logic                           out_last
);
  import dsdh_pkg::*;

  localparam int WW = BIN_W + 3;

  logic signed [WW-1:0] ce_re, le_re, re_re, ce_im, le_im, re_im;
  logic signed [WW-1:0] wr, wi;
  logic signed [WW-1:0] nwr, nwi, ncr, nci;
  logic [BIN_W-1:0]     acr, aci;
  logic [WW-2:0]        awr, awi;

  logic                 v1_r, v2_r, ov_r;
  logic [IDX_W-1:0]     idx1_r, idx2_r, idx3_r;
  logic                 last1_r, last2_r, last3_r;
  logic [BIN_W-1:0]     ar1_r, ai1_r;
  logic [WW-2:0]        awr1_r, awi1_r;
  logic [2*BIN_W-1:0]   sqr2_r, sqi2_r;
  logic [2*WW-3:0]      swr2_r, swi2_r;
  logic [2*BIN_W:0]     msum;
  logic [2*WW-2:0]      wsum;
  logic [MAG_W-1:0]     mag3_r, win3_r;

  assign adv = !ov_r || out_ready;

  always_comb begin
    ce_re = WW'(c.re);
    le_re = WW'(l.re);
    re_re = WW'(r.re);
    ce_im = WW'(c.im);
    le_im = WW'(l.im);
    re_im = WW'(r.im);
    case (mode)
      WM_LO: begin
        wr = (ce_re - re_re) <<< 1;
        wi = (ce_im - re_im) <<< 1;
      end
      WM_HI: begin
        wr = (ce_re - le_re) <<< 1;
        wi = (ce_im - le_im) <<< 1;
      end
      default: begin
        wr = (ce_re <<< 1) - le_re - re_re;
        wi = (ce_im <<< 1) - le_im - re_im;
      end
    endcase
    nwr = -wr;
    nwi = -wi;
    ncr = -ce_re;
    nci = -ce_im;
    awr = wr[WW-1] ? nwr[WW-2:0] : wr[WW-2:0];
    awi = wi[WW-1] ? nwi[WW-2:0] : wi[WW-2:0];
    acr = ce_re[WW-1] ? ncr[BIN_W-1:0] : ce_re[BIN_W-1:0];
    aci = ce_im[WW-1] ? nci[BIN_W-1:0] : ce_im[BIN_W-1:0];
    msum = (2*BIN_W+1)'(sqr2_r) + (2*BIN_W+1)'(sqi2_r);
    wsum = (2*WW-1)'(swr2_r) + (2*WW-1)'(swi2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      ov_r <= v2_r;
    end
  end

  // The shifted sums stay below 2^48 for every bin value, so the
  // saturation limit is never reached and a zero extension is exact.
  always_ff @(posedge clk) begin
    if (adv) begin
      idx1_r  <= in_idx;
      last1_r <= in_last;
      ar1_r   <= acr;
      ai1_r   <= aci;
      awr1_r  <= awr;
      awi1_r  <= awi;
      idx2_r  <= idx1_r;
      last2_r <= last1_r;
      sqr2_r  <= ar1_r * ar1_r;
      sqi2_r  <= ai1_r * ai1_r;
      swr2_r  <= awr1_r * awr1_r;
      swi2_r  <= awi1_r * awi1_r;
      idx3_r  <= idx2_r;
      last3_r <= last2_r;
      mag3_r  <= MAG_W'(msum[2*BIN_W:16]);
      win3_r  <= MAG_W'(wsum[2*WW-2:18]);
    end
  end

  assign out_valid     = ov_r;
  assign out_bin_index = idx3_r;
  assign out_mag_sq    = mag3_r;
  assign out_win_sq    = win3_r;
  assign out_last      = last3_r;

endmodule

// ----- hdl/damped_sliding_dft_hann.sv -----
// Damped sliding DFT with frequency-domain Hann window, top level.
// A request is taken in the idle state, the read and delta states form the delta, and the
// ring steps run; each active bin's result passes through the result pipeline registers.
// A new request is taken only once the bin ring has made its revolution through the single
// update unit; a result stalled at the output holds the ring.
// Reset (synchronous, active low) zeroes all bins and the sample pointer; old samples read as zero.
module damped_sliding_dft_hann #(
  parameter int SAMPLE_COUNT = dsdh_pkg::SAMPLE_COUNT_DEF,
  parameter int BIN_COUNT    = dsdh_pkg::BIN_COUNT_DEF,
  parameter int SAMPLE_WIDTH = dsdh_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dsdh_pkg::IDX_W-1:0]         out_bin_index,
  output logic [dsdh_pkg::MAG_W-1:0]         out_mag_sq,
  output logic [dsdh_pkg::MAG_W-1:0]         out_win_sq,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [dsdh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dsdh_pkg::CFG_W-1:0]         cfg_data
);
  import dsdh_pkg::*;

  localparam int BW  = $clog2(BIN_COUNT);
  localparam int PW  = $clog2(SAMPLE_COUNT);
  localparam int SPW = $clog2(BIN_COUNT + 2);
  localparam int DW  = SAMPLE_WIDTH + 10;
  localparam int QW  = SAMPLE_WIDTH + TW_W;
  localparam logic signed [TW_W-1:0] RPOW = rpow_q17(SAMPLE_COUNT);
  localparam logic [6:0] TOP7 = 7'(BIN_COUNT - 1);
  localparam logic [BW-1:0] TOP_BIN = BW'(BIN_COUNT - 1);

  // Sequencer. A request reads the oldest sample from the history RAM, forms
  // delta = sample - r^N * oldest in Q8, writes the new sample back, and then
  // rotates the bin ring once. The ring starts every request with bin 0 at
  // its tail cell, so the step count tells which bin sits where.
  dsdh_state_t       state_r, state_nxt;
  logic [SPW-1:0]    step_r, step_nxt;
  logic [PW-1:0]     ptr_r;
  logic              lap_r;
  logic [CFG_W-1:0]  start_r, end_r;
  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic signed [QW-1:0]           prod_r;
  logic signed [DW-1:0]           delta_r;

  logic              ram_re, ram_we, shift_en, emit_try, adv;
  logic [SAMPLE_WIDTH-1:0] ram_rdata;
  logic signed [SAMPLE_WIDTH-1:0] old_s;
  logic signed [QW-1:0]           prod_nxt;
  logic signed [QW-1:0]           prod_h;
  logic signed [DW-1:0]           delta_nxt;

  // Active range, clamped to the bins that exist.
  logic [BW-1:0] lo, hi, hi_c, lo_m, hi_p;

  always_comb begin
    lo   = (7'(start_r) > TOP7) ? TOP_BIN : BW'(start_r);
    hi_c = (7'(end_r) > TOP7) ? TOP_BIN : BW'(end_r);
    hi   = (hi_c < lo) ? lo : hi_c;
    lo_m = (lo == '0) ? lo : lo - BW'(1);
    hi_p = (hi == TOP_BIN) ? hi : hi + BW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= CFG_W'(31);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_BIN: start_r <= cfg_data;
        REG_END_BIN:   end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    shift_en  = 1'b0;
    emit_try  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ram_re    = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_DELTA;
      end
      ST_DELTA: begin
        ram_we    = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_ROT;
      end
      ST_ROT: begin
        // Everything waits while a finished result is stalled at the output.
        if (adv) begin
          shift_en = (step_r < SPW'(BIN_COUNT));
          emit_try = (step_r >= SPW'(2));
          if (step_r == SPW'(BIN_COUNT + 1)) begin
            step_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            step_nxt = step_r + SPW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      ptr_r   <= '0;
      lap_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (ram_we) begin
        if (ptr_r == PW'(SAMPLE_COUNT - 1)) begin
          ptr_r <= '0;
          lap_r <= 1'b1;
        end else begin
          ptr_r <= ptr_r + PW'(1);
        end
      end
    end
  end

  // Until the pointer has wrapped once, the entry it reads was never written
  // and stands for a zero sample.
  always_comb begin
    old_s     = lap_r ? $signed(ram_rdata) : '0;
    prod_nxt  = RPOW * old_s;
    prod_h    = prod_r + QW'(256);
    delta_nxt = (DW'(sample_r) <<< 8) - DW'($signed(prod_h[QW-1:9]));
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r <= in_sample;
    end
    if (state_r == ST_READ) begin
      prod_r <= prod_nxt;
    end
    if (state_r == ST_DELTA) begin
      delta_r <= delta_nxt;
    end
  end

  dsdh_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (SAMPLE_COUNT)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (sample_r),
    .re    (ram_re),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // Bin ring. Cell 0 takes the updated tail bin; every other cell takes its
  // lower neighbor. After BIN_COUNT shifts the ring is back where it started.
  bin_t          ring_q [BIN_COUNT];
  bin_t          upd_out;
  logic [BW-1:0] upd_tag;
  logic          upd_hit;

  assign upd_tag = BW'(step_r);
  assign upd_hit = (upd_tag >= lo_m) && (upd_tag <= hi_p);

  dsdh_upd #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .BIN_COUNT    (BIN_COUNT),
    .DELTA_W      (DW)
  ) u_upd (
    .tag    (upd_tag),
    .do_upd (upd_hit),
    .delta  (delta_r),
    .cur    (ring_q[BIN_COUNT-1]),
    .nxt    (upd_out)
  );

  for (genvar i = 0; i < BIN_COUNT; i++) begin : g_ring
    if (i == 0) begin : g_head
      dsdh_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (shift_en),
        .d     (upd_out),
        .q     (ring_q[i])
      );
    end else begin : g_body
      dsdh_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (shift_en),
        .d     (ring_q[i-1]),
        .q     (ring_q[i])
      );
    end
  end

  // Result taps. While bin k+1 has just left the update unit (cell 0), bin k
  // sits in cell 1 and bin k-1 in cell 2, all three current. The top bin is
  // taken at the last step, after the ring has stopped, from cells 0 and 1.
  logic [BW-1:0] k_sel;
  logic [6:0]    k7;
  logic          k_top_step;
  bin_t          tap_c, tap_l, tap_r;
  win_mode_t     k_mode;
  logic          emit_hit;

  always_comb begin
    k_top_step = (step_r == SPW'(BIN_COUNT + 1));
    if (k_top_step) begin
      k_sel = TOP_BIN;
      tap_c = ring_q[0];
      tap_l = ring_q[1];
      tap_r = ring_q[0];
    end else begin
      k_sel = BW'(step_r - SPW'(2));
      tap_c = ring_q[1];
      tap_l = ring_q[2];
      tap_r = ring_q[0];
    end
    if (k_sel == '0) begin
      k_mode = WM_LO;
    end else if (k_sel == TOP_BIN) begin
      k_mode = WM_HI;
    end else begin
      k_mode = WM_MID;
    end
    k7       = 7'(k_sel);
    emit_hit = emit_try && (k_sel >= lo) && (k_sel <= hi);
  end

  dsdh_mag u_mag (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_valid      (emit_hit),
    .in_idx        (k7[IDX_W-1:0]),
    .in_last       (k_sel == hi),
    .mode          (k_mode),
    .c             (tap_c),
    .l             (tap_l),
    .r             (tap_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_bin_index (out_bin_index),
    .out_mag_sq    (out_mag_sq),
    .out_win_sq    (out_win_sq),
    .out_last      (out_last)
  );

endmodule
